// ----- design/frustum_aabb_cull_defines.svh -----
// Assertion macros for the frustum box culler.
// Used by the top level only; the asserting module supplies i_clk and i_rst_n.
`ifndef FRUSTUM_AABB_CULL_DEFINES_SVH
`define FRUSTUM_AABB_CULL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FRCULL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FRCULL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/frcull_pkg.sv -----
// Package for the frustum box culler: widths, command codes, payload types
// and small helpers. No dependencies.
`default_nettype none

package frcull_pkg;

    localparam int COORD_W      = 32;   // signed coordinate width
    localparam int FRAC_BITS    = 16;   // fixed point fraction bits
    localparam int PLANE_COUNT  = 6;
    localparam int CORNER_COUNT = 8;
    localparam int AXIS_COUNT   = 3;
    localparam int STEP_COUNT   = PLANE_COUNT * AXIS_COUNT;
    localparam int SUM_W        = 2 * COORD_W - FRAC_BITS + 2;
    // ram read, product, accumulate, offset compare
    localparam int DRAIN_LEN    = 4;

    localparam logic [1:0] OP_LOAD_PLANE  = 2'd0;
    localparam logic [1:0] OP_LOAD_CORNER = 2'd1;
    localparam logic [1:0] OP_TEST_BOX    = 2'd2;

    typedef logic signed [COORD_W-1:0]     t_coord;
    typedef logic signed [COORD_W:0]       t_wide;
    typedef logic signed [2*COORD_W-1:0]   t_prod;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef t_coord [AXIS_COUNT-1:0]       t_coord3;
    typedef t_wide  [AXIS_COUNT-1:0]       t_wide3;

    typedef struct packed {
        logic [1:0]         operation;
        logic [2:0]         slot;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic signed [31:0] plane_offset;
        logic [30:0]        half_x;
        logic [30:0]        half_y;
        logic [30:0]        half_z;
    } t_cmd;

    typedef struct packed {
        logic answered;
        logic visible;
    } t_result;

    typedef struct packed {
        t_coord  offset;
        t_coord3 normal;
    } t_plane;

    typedef struct packed {
        logic clear;    // new box: drop the sticky cull flag
        logic valid;    // normal and vertex data valid this cycle
        logic first;    // first axis of a plane
        logic last;     // last axis of a plane
    } t_mac_ctl;

    typedef struct packed {
        logic valid;
        logic first;
    } t_face_ctl;

    function automatic t_coord3 cmd_vec(input t_cmd c);
        t_coord3 v;
        v[0] = c.value_x[COORD_W-1:0];
        v[1] = c.value_y[COORD_W-1:0];
        v[2] = c.value_z[COORD_W-1:0];
        return v;
    endfunction

    function automatic t_coord3 cmd_half(input t_cmd c);
        t_coord3 h;
        h[0] = t_coord'({1'b0, c.half_x[COORD_W-2:0]});
        h[1] = t_coord'({1'b0, c.half_y[COORD_W-2:0]});
        h[2] = t_coord'({1'b0, c.half_z[COORD_W-2:0]});
        return h;
    endfunction

    function automatic t_coord sat_coord(input t_wide e);
        t_coord s;
        if (e[COORD_W] != e[COORD_W-1]) begin
            s = e[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            s = e[COORD_W-1:0];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- design/frcull_ram.sv -----
// Simple dual-port synchronous RAM, one write and one read port,
// registered read data. No dependencies.
`default_nettype none

module frcull_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- design/frcull_plane_unit.sv -----
// Plane test datapath: near/far vertex pick, two shared multipliers,
// per-plane accumulation and offset compare. Uses frcull_pkg.
`default_nettype none

module frcull_plane_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire frcull_pkg::t_mac_ctl i_ctl,
    input  wire frcull_pkg::t_coord  i_normal,
    input  wire frcull_pkg::t_coord  i_hi,
    input  wire frcull_pkg::t_coord  i_lo,
    input  wire frcull_pkg::t_coord  i_offset,
    output logic                     o_cull
);
    import frcull_pkg::*;

    logic   pos;
    t_coord near_v;
    t_coord far_v;

    // stage 1: products
    t_prod  r_prod_n;
    t_prod  r_prod_p;
    t_coord r_s1_off;
    logic   r_s1_valid;
    logic   r_s1_first;
    logic   r_s1_last;

    // stage 2: running sums
    t_sum   sh_n;
    t_sum   sh_p;
    t_sum   r_acc_n;
    t_sum   r_acc_p;
    t_coord r_s2_off;
    logic   r_s2_last;

    t_sum   off_ext;
    logic   r_cull;

    // normal counts as positive only when strictly above zero
    assign pos    = !i_normal[COORD_W-1] && (|i_normal);
    assign near_v = pos ? i_lo : i_hi;
    assign far_v  = pos ? i_hi : i_lo;

    always_ff @(posedge i_clk) begin
        r_prod_n <= i_normal * near_v;
        r_prod_p <= i_normal * far_v;
        r_s1_off <= i_offset;
        r_s1_first <= i_ctl.first;
        r_s1_last  <= i_ctl.last;
    end

    // floor shift is just dropping the fraction bits of the signed product
    assign sh_n = t_sum'($signed(r_prod_n[2*COORD_W-1:FRAC_BITS]));
    assign sh_p = t_sum'($signed(r_prod_p[2*COORD_W-1:FRAC_BITS]));

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_acc_n  <= r_s1_first ? sh_n : r_acc_n + sh_n;
            r_acc_p  <= r_s1_first ? sh_p : r_acc_p + sh_p;
            r_s2_off <= r_s1_off;
        end
    end

    assign off_ext = t_sum'(r_s2_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_last  <= 1'b0;
            r_cull     <= 1'b0;
        end else begin
            r_s1_valid <= i_ctl.valid;
            r_s2_last  <= r_s1_valid && r_s1_last;
            if (i_ctl.clear) begin
                r_cull <= 1'b0;
            end else if (r_s2_last && (r_acc_n < off_ext) && (r_acc_p < off_ext)) begin
                r_cull <= 1'b1;
            end
        end
    end

    assign o_cull = r_cull;

endmodule

`default_nettype wire

// ----- design/frcull_face_unit.sv -----
// Face test: checks streamed frustum corners against the six box faces,
// keeping all-above / all-below flags per axis. Uses frcull_pkg.
`default_nettype none

module frcull_face_unit (
    input  wire logic                  i_clk,
    input  wire frcull_pkg::t_face_ctl i_ctl,
    input  wire frcull_pkg::t_coord3   i_corner,
    input  wire frcull_pkg::t_wide3    i_hi,
    input  wire frcull_pkg::t_wide3    i_lo,
    output logic                       o_cull
);
    import frcull_pkg::*;

    logic [AXIS_COUNT-1:0] above;
    logic [AXIS_COUNT-1:0] below;
    logic [AXIS_COUNT-1:0] r_above;
    logic [AXIS_COUNT-1:0] r_below;

    always_comb begin
        t_wide q;
        for (int a = 0; a < AXIS_COUNT; a++) begin
            q        = t_wide'($signed(i_corner[a]));
            above[a] = q >= $signed(i_hi[a]);
            below[a] = q <= $signed(i_lo[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_above <= i_ctl.first ? above : (r_above & above);
            r_below <= i_ctl.first ? below : (r_below & below);
        end
    end

    assign o_cull = |(r_above | r_below);

endmodule

`default_nettype wire

// ----- design/frustum_aabb_cull.sv -----
// Top level of the frustum box culler: command port, sequencer, plane and
// corner RAMs. Uses frcull_pkg, frcull_ram, frcull_plane_unit, frcull_face_unit.
`default_nettype none
`include "frustum_aabb_cull_defines.svh"

// Culls an axis-aligned box (center and half-extents, signed Q16.16) against
// a stored view frustum. A transaction is taken when start is high and busy
// is low; every transaction produces exactly one result, shown for a single
// cycle with o_done, and the receiver cannot hold it off. Plane and corner
// loads (and the unused operation code) finish in one cycle: o_done follows
// in the next cycle with answered low, and busy stays low, so loads can be
// issued every cycle while no box test holds busy. A box test raises busy and
// presents its result in the cycle in which busy drops and the next
// transaction can be taken. Busy covers the plane sequencer (six planes times
// three axes through one pair of multipliers fed from the plane RAM) and then
// the datapath drain; the eight frustum corners stream from the corner RAM
// during sequencer steps 0 to 7. A plane load with slot six or seven is
// dropped. Reading a plane or corner that was never loaded gives an
// unspecified answer.
module frustum_aabb_cull (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire frcull_pkg::t_cmd   i_cmd,
    output logic                    busy,
    output logic                    o_done,
    output frcull_pkg::t_result     o_result
);
    import frcull_pkg::*;

    localparam int STEP_W   = $clog2(STEP_COUNT);
    localparam int PLANE_AW = $clog2(PLANE_COUNT);
    localparam int CORNER_AW = $clog2(CORNER_COUNT);
    localparam int AXIS_W   = $clog2(AXIS_COUNT);
    localparam int DRAIN_W  = $clog2(DRAIN_LEN);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    t_state  r_state;
    logic    r_busy;
    logic    r_done;
    t_result r_result;

    logic [STEP_W-1:0]   r_step;
    logic [PLANE_AW-1:0] r_plane;
    logic [AXIS_W-1:0]   r_axis;
    logic [DRAIN_W-1:0]  r_drain;

    logic accept;
    logic accept_test;

    // box bounds, exact and saturated, captured at acceptance
    t_coord3 cmd_c;
    t_coord3 cmd_h;
    t_wide3  hi_x;
    t_wide3  lo_x;
    t_wide3  r_hi;
    t_wide3  r_lo;
    t_coord3 r_hi_sat;
    t_coord3 r_lo_sat;

    // RAM ports
    logic   plane_we;
    t_plane plane_wdata;
    t_plane plane_rdata;
    logic   corner_we;
    t_coord3 corner_rdata;

    // tags that line up with RAM read data
    logic              r_iss_plane;
    logic              r_iss_first;
    logic              r_iss_last;
    logic [AXIS_W-1:0] r_iss_axis;
    logic              r_iss_corner;
    logic              r_iss_corner_first;

    t_mac_ctl  mac_ctl;
    t_face_ctl face_ctl;
    logic      plane_cull;
    logic      face_cull;

    assign accept      = start && !r_busy;
    assign accept_test = accept && (i_cmd.operation == OP_TEST_BOX);

    // ---------------------------------------------------------------
    // Box bounds
    // ---------------------------------------------------------------
    assign cmd_c = cmd_vec(i_cmd);
    assign cmd_h = cmd_half(i_cmd);

    always_comb begin
        for (int a = 0; a < AXIS_COUNT; a++) begin
            hi_x[a] = t_wide'($signed(cmd_c[a])) + t_wide'($signed(cmd_h[a]));
            lo_x[a] = t_wide'($signed(cmd_c[a])) - t_wide'($signed(cmd_h[a]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_test) begin
            r_hi <= hi_x;
            r_lo <= lo_x;
            for (int a = 0; a < AXIS_COUNT; a++) begin
                r_hi_sat[a] <= sat_coord(hi_x[a]);
                r_lo_sat[a] <= sat_coord(lo_x[a]);
            end
        end
    end

    // ---------------------------------------------------------------
    // State RAMs: loads write straight from the command port
    // ---------------------------------------------------------------
    assign plane_we = accept && (i_cmd.operation == OP_LOAD_PLANE)
                      && (i_cmd.slot < 3'(PLANE_COUNT));
    assign plane_wdata.offset = i_cmd.plane_offset[COORD_W-1:0];
    assign plane_wdata.normal = cmd_c;
    assign corner_we = accept && (i_cmd.operation == OP_LOAD_CORNER);

    frcull_ram #(
        .WIDTH ($bits(t_plane)),
        .DEPTH (PLANE_COUNT)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (plane_we),
        .i_waddr (i_cmd.slot[PLANE_AW-1:0]),
        .i_wdata (plane_wdata),
        .i_raddr (r_plane),
        .o_rdata (plane_rdata)
    );

    frcull_ram #(
        .WIDTH ($bits(t_coord3)),
        .DEPTH (CORNER_COUNT)
    ) u_corner_ram (
        .i_clk   (i_clk),
        .i_we    (corner_we),
        .i_waddr (i_cmd.slot[CORNER_AW-1:0]),
        .i_wdata (cmd_c),
        .i_raddr (r_step[CORNER_AW-1:0]),
        .o_rdata (corner_rdata)
    );

    // ---------------------------------------------------------------
    // Sequencer: one plane axis per cycle, corners during steps 0..7
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_result <= '0;
            r_step   <= '0;
            r_plane  <= '0;
            r_axis   <= '0;
            r_drain  <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept_test) begin
                        r_state <= ST_RUN;
                        r_busy  <= 1'b1;
                        r_step  <= '0;
                        r_plane <= '0;
                        r_axis  <= '0;
                    end else if (accept) begin
                        // loads and the unused code answer at once
                        r_done   <= 1'b1;
                        r_result <= '0;
                    end
                end
                ST_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (r_axis == AXIS_W'(AXIS_COUNT - 1)) begin
                        r_axis  <= '0;
                        r_plane <= r_plane + 1'b1;
                    end else begin
                        r_axis <= r_axis + 1'b1;
                    end
                    if (r_step == STEP_W'(STEP_COUNT - 1)) begin
                        r_state <= ST_DRAIN;
                        r_drain <= DRAIN_W'(DRAIN_LEN - 1);
                    end
                end
                ST_DRAIN: begin
                    if (r_drain == '0) begin
                        r_state           <= ST_IDLE;
                        r_busy            <= 1'b0;
                        r_done            <= 1'b1;
                        r_result.answered <= 1'b1;
                        r_result.visible  <= !(plane_cull || face_cull);
                    end else begin
                        r_drain <= r_drain - 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    // read issued this cycle, data and tags arrive together next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_plane  <= 1'b0;
            r_iss_corner <= 1'b0;
        end else begin
            r_iss_plane  <= (r_state == ST_RUN);
            r_iss_corner <= (r_state == ST_RUN) && (r_step < STEP_W'(CORNER_COUNT));
        end
    end

    always_ff @(posedge i_clk) begin
        r_iss_first        <= (r_axis == '0);
        r_iss_last         <= (r_axis == AXIS_W'(AXIS_COUNT - 1));
        r_iss_axis         <= r_axis;
        r_iss_corner_first <= (r_step == '0);
    end

    // ---------------------------------------------------------------
    // Datapaths
    // ---------------------------------------------------------------
    assign mac_ctl.clear = accept_test;
    assign mac_ctl.valid = r_iss_plane;
    assign mac_ctl.first = r_iss_first;
    assign mac_ctl.last  = r_iss_last;

    frcull_plane_unit u_plane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_normal (plane_rdata.normal[r_iss_axis]),
        .i_hi     (r_hi_sat[r_iss_axis]),
        .i_lo     (r_lo_sat[r_iss_axis]),
        .i_offset (plane_rdata.offset),
        .o_cull   (plane_cull)
    );

    assign face_ctl.valid = r_iss_corner;
    assign face_ctl.first = r_iss_corner_first;

    frcull_face_unit u_face (
        .i_clk    (i_clk),
        .i_ctl    (face_ctl),
        .i_corner (corner_rdata),
        .i_hi     (r_hi),
        .i_lo     (r_lo),
        .o_cull   (face_cull)
    );

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `FRCULL_ASSERT_NEXT(a_load_answers,
        start && !busy && i_cmd.operation != OP_TEST_BOX,
        o_done && !o_result.answered && !busy,
        "load transaction not answered in next cycle")
    `FRCULL_ASSERT_NEXT(a_test_holds,
        start && !busy && i_cmd.operation == OP_TEST_BOX,
        busy && !o_done,
        "box test did not start the sequencer")
    `FRCULL_ASSERT_IMP(a_answer_after_drain,
        o_done && o_result.answered,
        $past(r_state == ST_DRAIN) && !busy,
        "box answer without a finished drain")

endmodule

`default_nettype wire
